/* rtl/bpa_pkg.sv */
// Package for the bitmap page allocator: sizes, codes, the RAM request struct
// and the free-bit search helpers.
// No dependencies; every other file of the block but bpa_ram imports it.
package bpa_pkg;

  // Heap geometry. PAGE_BYTES must be a power of two.
  localparam int unsigned PAGE_COUNT  = 1024;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned STATUS_W    = 2;

  // The used map is stored as words of WORD_BITS pages each.
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned WORD_COUNT  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned PIDX_W      = WORD_IDX_W + BIT_W;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } state_e;

  typedef logic [WORD_BITS-1:0] word_t;

  // One read port and one write port of the map RAM.
  typedef struct packed {
    logic                  re;
    logic [WORD_IDX_W-1:0] raddr;
    logic                  we;
    logic [WORD_IDX_W-1:0] waddr;
    word_t                 wdata;
  } ram_req_t;

  // Bits of a word that lie beyond the last page; they always count as used.
  function automatic word_t pad_mask(input logic [WORD_IDX_W-1:0] w);
    word_t m;
    m = '0;
    for (int unsigned b = 0; b < WORD_BITS; b++) begin
      m[b] = ((int'(w) * WORD_BITS + b) >= PAGE_COUNT);
    end
    return m;
  endfunction

  // Lowest clear bit of a map word.
  function automatic logic [BIT_W-1:0] first_zero_bit(input word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Lowest word whose summary bit says it still has a free page.
  function automatic logic [WORD_IDX_W-1:0] first_zero_word(
    input logic [WORD_COUNT-1:0] v
  );
    logic [WORD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_COUNT - 1; i >= 0; i--) begin
      if (!v[i]) idx = WORD_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

/* rtl/bpa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bpa_ctrl.sv */
// Allocator control: request decode, summary search, read-modify-write of the
// used map and the result register. Depends on bpa_pkg; drives one bpa_ram.
module bpa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          operation_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    page_address_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    heap_base_i,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output logic [bpa_pkg::ADDR_W-1:0]    granted_address_o,
  output logic [bpa_pkg::STATUS_W-1:0]  status_o,
  output bpa_pkg::ram_req_t             ram_req_o,
  input  bpa_pkg::word_t                ram_rdata_i
);
  import bpa_pkg::*;

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [WORD_IDX_W-1:0]   word_q, word_d;
  logic [BIT_W-1:0]        bit_q, bit_d;
  logic                    rd_valid_q, rd_valid_d;
  logic [WORD_COUNT-1:0]   summary_q, summary_d;
  logic [WORD_COUNT-1:0]   wvalid_q, wvalid_d;
  logic                    res_valid_q, res_valid_d;
  logic [ADDR_W-1:0]       res_addr_q, res_addr_d;
  status_e                 res_status_q, res_status_d;

  logic [ADDR_W-1:0]       offset;
  logic [ADDR_W-1:0]       off_page;
  logic                    in_range;
  logic [PIDX_W-1:0]       free_pidx;
  logic [WORD_IDX_W-1:0]   alloc_word;
  logic                    map_full;
  word_t                   cur_word;
  word_t                   pad;
  word_t                   new_word;
  logic [BIT_W-1:0]        alloc_bit;

  // Page index of a free request, checked against both ends of the heap.
  assign offset     = page_address_i - heap_base_i;
  assign off_page   = offset >> PAGE_SHIFT;
  assign in_range   = (page_address_i >= heap_base_i) && (off_page < ADDR_W'(PAGE_COUNT));
  assign free_pidx  = off_page[PIDX_W-1:0];

  // Summary search: one bit per map word, set when the word has no free page.
  assign alloc_word = first_zero_word(summary_q);
  assign map_full   = &summary_q;

  // Word read back from the RAM; a word never written reads as all free.
  assign cur_word   = rd_valid_q ? ram_rdata_i : '0;
  assign pad        = pad_mask(word_q);
  assign alloc_bit  = first_zero_bit(cur_word | pad);

  // Next state, RAM accesses and result.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    word_d       = word_q;
    bit_d        = bit_q;
    rd_valid_d   = rd_valid_q;
    summary_d    = summary_q;
    wvalid_d     = wvalid_q;
    res_valid_d  = 1'b0;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    ram_req_o    = '0;
    new_word     = cur_word;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d = op_e'(operation_i);
          if (op_e'(operation_i) == OP_ALLOC) begin
            if (map_full) begin
              res_valid_d  = 1'b1;
              res_addr_d   = '0;
              res_status_d = STATUS_FULL;
            end else begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = alloc_word;
              word_d          = alloc_word;
              rd_valid_d      = wvalid_q[alloc_word];
              state_d         = ST_MODIFY;
            end
          end else begin
            if (!in_range) begin
              res_valid_d  = 1'b1;
              res_addr_d   = '0;
              res_status_d = STATUS_RANGE;
            end else begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = free_pidx[PIDX_W-1:BIT_W];
              word_d          = free_pidx[PIDX_W-1:BIT_W];
              bit_d           = free_pidx[BIT_W-1:0];
              rd_valid_d      = wvalid_q[free_pidx[PIDX_W-1:BIT_W]];
              state_d         = ST_MODIFY;
            end
          end
        end
      end

      ST_MODIFY: begin
        if (op_q == OP_ALLOC) begin
          new_word           = cur_word | (word_t'(1) << alloc_bit);
          summary_d[word_q]  = &(new_word | pad);
          res_addr_d         = heap_base_i + (ADDR_W'({word_q, alloc_bit}) << PAGE_SHIFT);
        end else begin
          new_word           = cur_word & ~(word_t'(1) << bit_q);
          summary_d[word_q]  = 1'b0;
          res_addr_d         = '0;
        end
        ram_req_o.we     = 1'b1;
        ram_req_o.waddr  = word_q;
        ram_req_o.wdata  = new_word;
        wvalid_d[word_q] = 1'b1;
        res_valid_d      = 1'b1;
        res_status_d     = STATUS_OK;
        state_d          = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_valid_q  <= 1'b0;
      summary_q   <= '0;
      wvalid_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_valid_q  <= rd_valid_d;
      summary_q   <= summary_d;
      wvalid_q    <= wvalid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    word_q       <= word_d;
    bit_q        <= bit_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign result_valid_o    = res_valid_q;
  assign granted_address_o = res_addr_q;
  assign status_o          = res_status_q;

endmodule

/* rtl/bitmap_page_allocator_unit.sv */
// Top level of the bitmap page allocator: heap base register, control and
// the used-map RAM. Depends on bpa_pkg, bpa_ctrl and bpa_ram.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         start, busy                 operation_i, page_address_i
//   result    out        result_valid_o (strobe)     granted_address_o, status_o
//   config    in         cfg_valid_i, cfg_ready_o    cfg_data_i (heap base)
//
// A request is taken when start is high and busy is low. Allocate and in-range
// free requests read one map word from the RAM, then modify it and write it
// back. Full-heap and out-of-range requests answer without a RAM access.
// The result strobe is high for one cycle; the receiver cannot stall it.
// Reset clears the word valid bits and the summary, so the map reads as all
// free right away with no clearing pass.
module bitmap_page_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    page_address_i,
  output logic                          result_valid_o,
  output logic [bpa_pkg::ADDR_W-1:0]    granted_address_o,
  output logic [bpa_pkg::STATUS_W-1:0]  status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpa_pkg::ADDR_W-1:0]    cfg_data_i
);
  import bpa_pkg::*;

  logic [ADDR_W-1:0] heap_base_q;
  ram_req_t          ram_req;
  word_t             ram_rdata;

  // Heap base register; a configuration transfer is always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      heap_base_q <= cfg_data_i;
    end
  end

  // Request sequencing and map update.
  bpa_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .operation_i       (operation_i),
    .page_address_i    (page_address_i),
    .heap_base_i       (heap_base_q),
    .busy_o            (busy),
    .result_valid_o    (result_valid_o),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .ram_req_o         (ram_req),
    .ram_rdata_i       (ram_rdata)
  );

  // Used map, one word of pages per entry.
  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* bench/page_grant_checker.sv */
// Result checker for the bitmap page allocator bench: watches the request,
// result and heap base channels, predicts each grant and compares it.
// Depends on bpa_pkg for sizes, status codes and operation codes.
`timescale 1ns / 100ps

module page_grant_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          operation_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    page_address_i,
  input  logic                          result_valid_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    granted_address_i,
  input  logic [bpa_pkg::STATUS_W-1:0]  status_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    cfg_data_i,
  output int                            mismatch_count_o,
  output int                            grants_pending_o
);
  import bpa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } grant_t;

  // Shadow copy of the heap base register and of the used map.
  logic [ADDR_W-1:0]   heap_base;
  bit [PAGE_COUNT-1:0] page_used;
  grant_t              expected_grants[$];
  grant_t              oldest_grant;

  // Works out the answer to one request and updates the shadow map.
  function automatic grant_t predict_grant(input op_e op, input logic [ADDR_W-1:0] addr);
    grant_t            g;
    bit                found;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] pidx;
    g.addr   = '0;
    g.status = STATUS_OK;
    found    = 1'b0;
    if (op == OP_ALLOC) begin
      // First fit: the lowest free page wins, its address wraps at 32 bits.
      for (int i = 0; i < PAGE_COUNT; i++) begin
        if (!found && !page_used[i]) begin
          found        = 1'b1;
          page_used[i] = 1'b1;
          g.addr       = heap_base + ADDR_W'(i) * ADDR_W'(PAGE_BYTES);
        end
      end
      if (!found) begin
        g.status = STATUS_FULL;
      end
    end else begin
      // A free outside the heap leaves the map alone.
      if (addr < heap_base) begin
        g.status = STATUS_RANGE;
      end else begin
        offset = addr - heap_base;
        pidx   = offset / ADDR_W'(PAGE_BYTES);
        if (pidx >= ADDR_W'(PAGE_COUNT)) begin
          g.status = STATUS_RANGE;
        end else begin
          page_used[pidx] = 1'b0;
        end
      end
    end
    return g;
  endfunction

  // Predict on every request transfer, compare on every result strobe.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base = '0;
      page_used = '0;
      expected_grants.delete();
      mismatch_count_o = 0;
      grants_pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        heap_base = cfg_data_i;
      end
      // The new expectation goes to the back, so a result that lands on the
      // same edge still pairs with the oldest one.
      if (start_i && !busy_i) begin
        expected_grants.push_back(predict_grant(op_e'(operation_i), page_address_i));
      end
      if (result_valid_i) begin
        if (expected_grants.size() == 0) begin
          $display("[%0t] unexpected result: expected none, got addr %h status %0d",
                   $time, granted_address_i, status_i);
          mismatch_count_o++;
        end else begin
          oldest_grant = expected_grants.pop_front();
          if (granted_address_i !== oldest_grant.addr) begin
            $display("[%0t] granted_address mismatch: expected %h, got %h",
                     $time, oldest_grant.addr, granted_address_i);
            mismatch_count_o++;
          end
          if (status_i !== oldest_grant.status) begin
            $display("[%0t] status mismatch: expected %0d, got %0d",
                     $time, oldest_grant.status, status_i);
            mismatch_count_o++;
          end
        end
      end
      grants_pending_o = expected_grants.size();
    end
  end

endmodule

/* bench/bitmap_page_allocator_unit_tb.sv */
// Top of the bitmap page allocator bench: clock, reset, request and heap base
// stimulus, and the verdict. Depends on bpa_pkg, the block and page_grant_checker.
`timescale 1ns / 100ps

module bitmap_page_allocator_unit_tb;
  import bpa_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  op_e                 req_op;
  logic [ADDR_W-1:0]   page_address_i;
  logic                result_valid_o;
  logic [ADDR_W-1:0]   granted_address_o;
  logic [STATUS_W-1:0] status_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [ADDR_W-1:0]   cfg_data_i;

  int                  mismatch_count;
  int                  grants_pending;
  bit                  req_taken_q;
  bit                  cfg_taken_q;
  logic [ADDR_W-1:0]   heap_base_now;
  int                  requests_sent;
  int                  base_settings;

  localparam logic [ADDR_W-1:0] HEAP_SPAN  = ADDR_W'(PAGE_COUNT) * ADDR_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_MASK  = ADDR_W'(PAGE_BYTES - 1);

  bitmap_page_allocator_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (req_op),
    .page_address_i    (page_address_i),
    .result_valid_o    (result_valid_o),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  page_grant_checker checker_u (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .operation_i       (req_op),
    .page_address_i    (page_address_i),
    .result_valid_i    (result_valid_o),
    .granted_address_i (granted_address_o),
    .status_i          (status_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .mismatch_count_o  (mismatch_count),
    .grants_pending_o  (grants_pending)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Transfers seen at the rising edge, read back by the driver at the falling edge.
  always_ff @(posedge clk_i) begin
    req_taken_q <= start && !busy;
    cfg_taken_q <= cfg_valid_i && cfg_ready_o;
  end

  // Issues one request and returns at the falling edge after its transfer.
  task automatic request_page(input op_e op, input logic [ADDR_W-1:0] addr);
    start          = 1'b1;
    req_op         = op;
    page_address_i = addr;
    do @(negedge clk_i); while (!req_taken_q);
    requests_sent++;
  endtask

  task automatic pause_requests(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Waits until every expected grant has come back, then lets the block settle.
  task automatic wait_drained();
    start = 1'b0;
    for (int n = 0; n < 4000 && grants_pending != 0; n++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes the heap base while the block is idle.
  task automatic write_heap_base(input logic [ADDR_W-1:0] base);
    wait_drained();
    repeat ($urandom_range(0, 3)) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = base;
    do @(negedge clk_i); while (!cfg_taken_q);
    cfg_valid_i   = 1'b0;
    heap_base_now = base;
    base_settings++;
  endtask

  // Random requests. Most frees hit a page inside the heap, some carry
  // arbitrary addresses and some sit right at the heap edges.
  task automatic run_random(input int count, input int alloc_pct, input bit idling);
    logic [ADDR_W-1:0] addr;
    int                pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        request_page(OP_ALLOC, $urandom());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          addr = heap_base_now + ADDR_W'($urandom_range(0, PAGE_COUNT - 1)) * ADDR_W'(PAGE_BYTES);
          if ($urandom_range(0, 1) != 0) begin
            addr = addr + ($urandom() & PAGE_MASK);
          end
        end else if (pick < 80) begin
          addr = $urandom();
        end else begin
          case ($urandom_range(0, 3))
            0:       addr = heap_base_now - 1;
            1:       addr = heap_base_now + HEAP_SPAN;
            2:       addr = heap_base_now + HEAP_SPAN - 1;
            default: addr = heap_base_now;
          endcase
        end
        request_page(OP_FREE, addr);
      end
      if (idling && $urandom_range(0, 99) < 20) begin
        pause_requests($urandom_range(1, 8));
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_op         = OP_ALLOC;
    page_address_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    heap_base_now  = '0;
    requests_sent  = 0;
    base_settings  = 1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Heap at address zero: page zero is granted at address zero.
    request_page(OP_ALLOC, 32'h0000_0000);
    request_page(OP_ALLOC, 32'hFFFF_FFFF);
    request_page(OP_ALLOC, 32'h1234_5678);
    // Free inside a page, then the same page again while it is free.
    request_page(OP_FREE, 32'h0000_1ABC);
    request_page(OP_FREE, 32'h0000_1000);
    request_page(OP_ALLOC, 32'h0000_0000);
    // Frees past the end of the heap, at the top of the address space and in the last page.
    request_page(OP_FREE, HEAP_SPAN);
    request_page(OP_FREE, 32'hFFFF_FFFF);
    request_page(OP_FREE, HEAP_SPAN - 1);

    // Frees below the heap and inside it.
    write_heap_base(32'h8000_0000);
    request_page(OP_FREE, 32'h7FFF_FFFF);
    request_page(OP_ALLOC, 32'h0000_0000);
    request_page(OP_FREE, 32'h8000_3FFF);
    request_page(OP_FREE, 32'h0000_0000);

    // Grants that wrap past the top of the address space.
    write_heap_base(32'hFFFF_F000);
    request_page(OP_ALLOC, 32'h0000_0000);
    request_page(OP_ALLOC, 32'h0000_0000);
    request_page(OP_FREE, 32'h0000_2000);
    request_page(OP_FREE, 32'hFFFF_F000);

    // Largest base: only one address lands inside the heap.
    write_heap_base(32'hFFFF_FFFF);
    request_page(OP_FREE, 32'hFFFF_FFFF);
    request_page(OP_ALLOC, 32'h0000_0000);
    request_page(OP_FREE, 32'hFFFF_FFFE);

    // Fill the heap past full, then work at the extremes and random bases.
    write_heap_base($urandom());
    run_random(1100, 99, 1'b1);
    write_heap_base(32'h0000_0000);
    run_random(80, 50, 1'b1);
    write_heap_base($urandom() & ~PAGE_MASK);
    run_random(350, 30, 1'b1);
    write_heap_base($urandom());
    run_random(200, 50, 1'b0);

    wait_drained();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d requests over %0d heap base settings, with full-heap,",
             requests_sent, base_settings);
    $display("wrapped-grant and out-of-range free cases among them.");
    if (mismatch_count == 0 && grants_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
